// ===== hdl/bri_pkg.sv =====
package bri_pkg;

  // Width of the raw word and of all range arithmetic (8 to 32).
  localparam int unsigned WORD_W = 32;
  // Widths of the port fields.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned USER_W = 1;
  localparam int unsigned CFG_IDX_W = 1;
  // Step counter of the remainder unit; it must hold WORD_W itself.
  localparam int unsigned CNT_W = $clog2(WORD_W + 1);

  typedef logic [WORD_W-1:0] word_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_LOW  = 1'b0,
    CFG_RANGE_HIGH = 1'b1
  } cfg_idx_e;

  // Threshold sequencer states.
  typedef enum logic [1:0] {
    ST_READY,
    ST_LOAD,
    ST_DIVIDE
  } thr_state_e;

endpackage

// ===== hdl/bounded_random_integer.sv =====
// Bounded random integer generator. Each raw word transferred on the slave
// stream is mapped into the inclusive range [range_low, range_high] by the
// multiply-and-reject method and yields exactly one transfer on the master
// stream: tdata holds the value and tuser holds the accepted flag. When the
// flag is low the word was rejected to keep the distribution exact, tdata
// is zero, and the host should supply a fresh word. A span that wraps to
// zero (range_low one above range_high, e.g. the full range) passes the
// word straight through as a signed value. Words are taken one per clock
// cycle while tready is high; a result passes from the input register
// through the product register into the output register, and
// back-pressure on the master side stalls the whole pipeline without
// dropping anything. The rejection threshold (2^WORD_W - span) mod span
// is worked out by a bit-serial remainder unit after every configuration
// write: while the unit loads and divides, the slave side holds tready low.
// After reset the range is [0, 0] and the threshold is ready at once.
module bounded_random_integer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [bri_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [bri_pkg::DATA_W-1:0]   cfg_wdata_i,
  // Raw words in.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [bri_pkg::DATA_W-1:0]   s_axis_tdata,  // [31:0] random_word
  // Bounded values out.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [bri_pkg::DATA_W-1:0]   m_axis_tdata,  // [31:0] value
  output logic [bri_pkg::USER_W-1:0]   m_axis_tuser   // [0] accepted
);
  import bri_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  word_t range_low_q, range_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= '0;
      range_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_RANGE_LOW:  range_low_q  <= cfg_wdata_i[WORD_W-1:0];
        CFG_RANGE_HIGH: range_high_q <= cfg_wdata_i[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Threshold sequencer: latches the span, then runs a restoring remainder
  // of (2^WORD_W - span) by span, one dividend bit per cycle.
  // ---------------------------------------------------------------------
  thr_state_e state_q, state_d;
  logic       item_ok, load_en, div_en;

  word_t           span_q, span_d;
  word_t           thresh_q;
  word_t           dividend_q;
  word_t           rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic [WORD_W:0]  rem_shift;

  assign span_d    = range_high_q - range_low_q + word_t'(1);
  assign rem_shift = {rem_q, dividend_q[WORD_W-1]};
  assign rem_d     = (rem_shift >= {1'b0, span_q})
                     ? word_t'(rem_shift - {1'b0, span_q})
                     : rem_shift[WORD_W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_READY:  state_d = ST_READY;
      ST_LOAD:   state_d = ST_DIVIDE;
      ST_DIVIDE: if (cnt_q == CNT_W'(1)) state_d = ST_READY;
      default:   state_d = ST_READY;
    endcase
    // A write restarts the computation from any state.
    if (cfg_we_i) state_d = ST_LOAD;
  end

  always_comb begin
    item_ok = 1'b0;
    load_en = 1'b0;
    div_en  = 1'b0;
    unique case (state_q)
      ST_READY:  item_ok = 1'b1;
      ST_LOAD:   load_en = 1'b1;
      ST_DIVIDE: div_en  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_READY;
      span_q   <= word_t'(1);   // range [0, 0]
      thresh_q <= '0;           // 2^WORD_W mod 1
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (load_en) begin
        span_q <= span_d;
        cnt_q  <= CNT_W'(WORD_W);
      end else if (div_en) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) thresh_q <= rem_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      dividend_q <= word_t'(0) - span_d;
      rem_q      <= '0;
    end else if (div_en) begin
      dividend_q <= {dividend_q[WORD_W-2:0], 1'b0};
      rem_q      <= rem_d;
    end
  end

  // ---------------------------------------------------------------------
  // Data pipeline: input register, product register, output register.
  // All stages advance together whenever the output register is free.
  // ---------------------------------------------------------------------
  logic adv;
  logic s_fire;

  logic  v1_q, v2_q, out_valid_q;
  word_t word1_q, word2_q;
  logic  full2_q;
  logic [2*WORD_W-1:0] prod2_q, prod_d;

  logic [DATA_W-1:0] value_d, value_q;
  logic              accepted_d, accepted_q;
  logic              reject;
  word_t             sum;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv && item_ok;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign prod_d = {{WORD_W{1'b0}}, word1_q} * {{WORD_W{1'b0}}, span_q};

  assign reject = prod2_q[WORD_W-1:0] < thresh_q;
  assign sum    = range_low_q + prod2_q[2*WORD_W-1:WORD_W];

  always_comb begin
    if (full2_q) begin
      value_d    = DATA_W'(signed'(word2_q));
      accepted_d = 1'b1;
    end else if (reject) begin
      value_d    = '0;
      accepted_d = 1'b0;
    end else begin
      value_d    = DATA_W'(signed'(sum));
      accepted_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= s_fire;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      word1_q    <= s_axis_tdata[WORD_W-1:0];
      word2_q    <= word1_q;
      prod2_q    <= prod_d;
      full2_q    <= (span_q == '0);
      value_q    <= value_d;
      accepted_q <= accepted_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = value_q;
  assign m_axis_tuser  = accepted_q;

endmodule
